>>> rtl/assert_macros.svh
// Assertion helpers; bodies drop out in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/mfs_pkg.sv
package mfs_pkg;

    localparam int MAX_DIM_DEF  = 8;
    localparam int CAPACITY_DEF = 64;

    localparam int DATA_W      = 32;
    localparam int DIM_W       = 4;
    localparam int IDX_W       = 3;
    localparam int CFG_IDX_W   = 1;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_COUNT,
        CFG_COL_COUNT
    } t_cfg_idx;

    typedef struct packed {
        logic signed [DATA_W-1:0] element;
        logic                     is_final;
    } t_qentry;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FETCH_I,
        ST_FETCH_J,
        ST_CMP,
        ST_WRI,
        ST_EMIT_RD,
        ST_EMIT_WAIT
    } t_state;

    // zero acts as one, anything above the limit acts as the limit
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] max_dim);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > max_dim) begin
            r = max_dim;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

>>> rtl/mfs_queue.sv
module mfs_queue
    import mfs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_qentry i_entry,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_valid,
    output t_qentry o_entry
);

    t_qentry           r_entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_entries[r_rptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entries[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/mfs_front.sv
module mfs_front
    import mfs_pkg::*;
#(
    parameter int MAX_DIM  = MAX_DIM_DEF,
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [DIM_W-1:0]         i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [DATA_W-1:0] i_element,
    input  logic                     i_q_full,
    output logic                     o_push,
    output t_qentry                  o_entry,
    output logic [CNT_W-1:0]         o_total,
    output logic [DIM_W-1:0]         o_cols
);

    logic [DIM_W-1:0]   r_row_count;
    logic [DIM_W-1:0]   r_col_count;
    logic [CNT_W-1:0]   r_loaded;
    logic [CNT_W-1:0]   n_loaded;

    logic [DIM_W-1:0]   rows_eff;
    logic [2*DIM_W-1:0] prod;
    logic               is_final;

    assign rows_eff = eff_dim(r_row_count, DIM_W'(MAX_DIM));
    assign o_cols   = eff_dim(r_col_count, DIM_W'(MAX_DIM));
    assign prod     = (2*DIM_W)'(rows_eff) * (2*DIM_W)'(o_cols);
    assign o_total  = (prod > (2*DIM_W)'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(prod);

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // the item that completes the matrix is tagged so the back end starts sorting;
    // a size shrunk mid-load below the stored count completes on the next item
    assign is_final = ((r_loaded + CNT_W'(1)) >= o_total);
    assign n_loaded = is_final ? '0 : r_loaded + CNT_W'(1);

    assign o_entry.element  = i_element;
    assign o_entry.is_final = is_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= DIM_RESET;
            r_col_count <= DIM_RESET;
            r_loaded    <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == CFG_ROW_COUNT)) begin
                r_row_count <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_idx == CFG_COL_COUNT)) begin
                r_col_count <= i_cfg_data;
            end
            if (o_push) begin
                r_loaded <= n_loaded;
            end
        end
    end

endmodule

>>> rtl/mfs_back.sv
`include "assert_macros.svh"

module mfs_back
    import mfs_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int CNT_W   = $clog2(CAPACITY + 1),
    localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [CNT_W-1:0]         i_total,
    input  logic [DIM_W-1:0]         i_cols,
    input  logic                     i_q_valid,
    input  t_qentry                  i_q_entry,
    output logic                     o_q_pop,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_sorted_value,
    output logic [IDX_W-1:0]         o_row_index,
    output logic [IDX_W-1:0]         o_col_index,
    output logic                     o_last
);

    logic signed [DATA_W-1:0] mem [CAPACITY];

    t_state r_state;
    t_state n_state;

    logic [ADDR_W-1:0]        r_wr;
    logic [ADDR_W-1:0]        r_i;
    logic [ADDR_W-1:0]        r_j;
    logic [ADDR_W-1:0]        r_k;
    logic [IDX_W-1:0]         r_row;
    logic [IDX_W-1:0]         r_col;
    logic signed [DATA_W-1:0] r_cur;
    logic signed [DATA_W-1:0] r_rd_data;

    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_value;
    logic [IDX_W-1:0]         r_out_row;
    logic [IDX_W-1:0]         r_out_col;
    logic                     r_out_last;

    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     out_load;

    logic pop_final;
    logic gt;
    logic j_last;
    logic i_last;
    logic k_last;
    logic col_wrap;
    logic out_free;
    logic one_elem;

    assign pop_final = i_q_valid && i_q_entry.is_final;
    assign gt        = r_cur > r_rd_data;
    assign j_last    = (CNT_W'(r_j) + CNT_W'(1)) == i_total;
    assign i_last    = (CNT_W'(r_i) + CNT_W'(2)) == i_total;
    assign k_last    = (CNT_W'(r_k) + CNT_W'(1)) == i_total;
    assign col_wrap  = (DIM_W'(r_col) + DIM_W'(1)) == i_cols;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign one_elem  = (i_total == CNT_W'(1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (pop_final) begin
                    n_state = one_elem ? ST_EMIT_RD : ST_FETCH_I;
                end
            end
            ST_FETCH_I:   n_state = ST_FETCH_J;
            ST_FETCH_J:   n_state = ST_CMP;
            ST_CMP: begin
                if (j_last) begin
                    n_state = ST_WRI;
                end
            end
            ST_WRI:       n_state = i_last ? ST_EMIT_RD : ST_FETCH_I;
            ST_EMIT_RD:   n_state = ST_EMIT_WAIT;
            ST_EMIT_WAIT: begin
                if (out_free) begin
                    n_state = k_last ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default:      n_state = ST_LOAD;
        endcase
    end

    // memory port and output register controls
    always_comb begin
        o_q_pop   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_wr;
        mem_wdata = i_q_entry.element;
        rd_addr   = r_i;
        out_load  = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_q_pop = i_q_valid;
                mem_we  = i_q_valid;
            end
            ST_FETCH_I: begin
                rd_addr = r_i;
            end
            ST_FETCH_J: begin
                rd_addr = r_j;
            end
            ST_CMP: begin
                // the value held in r_cur sinks to a[j], the smaller a[j] rides on in r_cur
                mem_we    = gt;
                mem_waddr = r_j;
                mem_wdata = r_cur;
                rd_addr   = r_j + ADDR_W'(1);
            end
            ST_WRI: begin
                mem_we    = 1'b1;
                mem_waddr = r_i;
                mem_wdata = r_cur;
            end
            ST_EMIT_RD: begin
                rd_addr = r_k;
            end
            ST_EMIT_WAIT: begin
                rd_addr  = r_k;
                out_load = out_free;
            end
            default: begin
                rd_addr = r_i;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_wr        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_q_pop) begin
                r_wr <= pop_final ? '0 : r_wr + ADDR_W'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOAD && pop_final) begin
            r_i   <= '0;
            r_k   <= '0;
            r_row <= '0;
            r_col <= '0;
        end
        if (r_state == ST_FETCH_I) begin
            r_j <= r_i + ADDR_W'(1);
        end
        if (r_state == ST_FETCH_J) begin
            r_cur <= r_rd_data;
        end
        if (r_state == ST_CMP) begin
            r_j <= r_j + ADDR_W'(1);
            if (gt) begin
                r_cur <= r_rd_data;
            end
        end
        if (r_state == ST_WRI) begin
            r_i <= r_i + ADDR_W'(1);
        end
        if (out_load) begin
            r_out_value <= r_rd_data;
            r_out_row   <= r_row;
            r_out_col   <= r_col;
            r_out_last  <= k_last;
            r_k         <= r_k + ADDR_W'(1);
            if (col_wrap) begin
                r_col <= '0;
                r_row <= r_row + IDX_W'(1);
            end else begin
                r_col <= r_col + IDX_W'(1);
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sorted_value = r_out_value;
    assign o_row_index    = r_out_row;
    assign o_col_index    = r_out_col;
    assign o_last         = r_out_last;

    `ASSERT_IMPLY(a_j_after_i, i_clk, i_rst_n, r_state == ST_CMP, r_j > r_i)
    `ASSERT_IMPLY(a_i_in_range, i_clk, i_rst_n, r_state == ST_WRI, (CNT_W'(r_i) + CNT_W'(2)) <= i_total)
    `ASSERT_IMPLY(a_k_in_range, i_clk, i_rst_n, r_state == ST_EMIT_RD || r_state == ST_EMIT_WAIT, CNT_W'(r_k) < i_total)

endmodule

>>> rtl/matrix_full_sorter.sv
// Load: one element per cycle into the store while the four-entry queue is not full.
// Sort: exchange sort on a one-write/one-read memory, one compare per cycle.
// Emission: one result at a time (registered memory read, then output register); a stalled output holds it.
// Reset (synchronous, active low): row and column counts return to 8, the load
//   count and queue clear; the element store is not cleared.
module matrix_full_sorter
    import mfs_pkg::*;
#(
    parameter int MAX_DIM  = MAX_DIM_DEF,
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [DIM_W-1:0]         i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [DATA_W-1:0] i_element,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_sorted_value,
    output logic [IDX_W-1:0]         o_row_index,
    output logic [IDX_W-1:0]         o_col_index,
    output logic                     o_last
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic             push;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    t_qentry          push_entry;
    t_qentry          q_entry;
    logic [CNT_W-1:0] total;
    logic [DIM_W-1:0] cols;

    mfs_front #(
        .MAX_DIM  (MAX_DIM),
        .CAPACITY (CAPACITY)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_element  (i_element),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_entry    (push_entry),
        .o_total    (total),
        .o_cols     (cols)
    );

    mfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    mfs_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_total        (total),
        .i_cols         (cols),
        .i_q_valid      (q_valid),
        .i_q_entry      (q_entry),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sorted_value (o_sorted_value),
        .o_row_index    (o_row_index),
        .o_col_index    (o_col_index),
        .o_last         (o_last)
    );

endmodule

>>> tb/tb_matrix_full_sorter.sv
module tb_matrix_full_sorter;
    import mfs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 480;
    localparam int DRAIN_CYCLES = 24;
    localparam int END_SETTLE   = 200;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS  = 10;

    localparam logic signed [DATA_W-1:0] ELEM_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] ELEM_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic                     last;
    } t_sorted_item;

    typedef enum logic {
        ROW_CFG,
        ROW_ELEM
    } t_stim_kind;

    typedef struct {
        t_stim_kind               kind;
        t_cfg_idx                 idx;
        logic [DIM_W-1:0]         dim;
        logic signed [DATA_W-1:0] element;
        bit                       typed;
        t_sorted_item             typed_item;
    } t_stim_row;

    logic                     i_clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    t_cfg_idx                 cfg_idx = CFG_ROW_COUNT;
    logic [DIM_W-1:0]         cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic signed [DATA_W-1:0] in_element = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] out_value;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic                     out_last;

    matrix_full_sorter i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_element      (in_element),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_sorted_value (out_value),
        .o_row_index    (out_row),
        .o_col_index    (out_col),
        .o_last         (out_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // sorter state as seen from outside
    logic signed [DATA_W-1:0] model_store [CAPACITY_DEF];
    int unsigned              model_loaded = 0;
    logic [DIM_W-1:0]         model_rows = DIM_RESET;
    logic [DIM_W-1:0]         model_cols = DIM_RESET;

    t_sorted_item fresh_items[$];
    t_sorted_item expected_sorted[$];
    t_stim_row    directed_rows[$];

    int failures  = 0;
    int gap_pct   = 0;
    int stall_pct = 0;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;

    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v);
        if (v == '0) return 1;
        if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
        return v;
    endfunction

    function automatic void load_and_sort(input logic signed [DATA_W-1:0] v);
        int unsigned              rows;
        int unsigned              cols;
        int unsigned              total;
        logic signed [DATA_W-1:0] tmp;
        t_sorted_item             it;
        rows  = clamp_dim(model_rows);
        cols  = clamp_dim(model_cols);
        total = rows * cols;
        if (total > CAPACITY_DEF) total = CAPACITY_DEF;
        // a full store drops the item but still triggers the sort
        if (model_loaded < CAPACITY_DEF) begin
            model_store[model_loaded] = v;
            model_loaded++;
        end
        if (model_loaded < total) return;
        for (int i = 0; i < total; i++) begin
            for (int j = i + 1; j < total; j++) begin
                if (model_store[i] > model_store[j]) begin
                    tmp            = model_store[i];
                    model_store[i] = model_store[j];
                    model_store[j] = tmp;
                end
            end
        end
        for (int k = 0; k < total; k++) begin
            it.value = model_store[k];
            it.row   = IDX_W'(k / cols);
            it.col   = IDX_W'(k % cols);
            it.last  = (k + 1 == total);
            fresh_items.push_back(it);
        end
        model_loaded = 0;
    endfunction

    function automatic void note_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
    endfunction

    function automatic t_stim_row stim_elem(input logic signed [DATA_W-1:0] v);
        t_stim_row r;
        r = '{ROW_ELEM, CFG_ROW_COUNT, '0, v, 1'b0, '0};
        return r;
    endfunction

    // 1x1 matrix: the item comes straight back at position 0,0 flagged last
    function automatic t_stim_row stim_single(input logic signed [DATA_W-1:0] v);
        t_stim_row r;
        r = '{ROW_ELEM, CFG_ROW_COUNT, '0, v, 1'b1, '{v, 3'd0, 3'd0, 1'b1}};
        return r;
    endfunction

    function automatic t_stim_row stim_cfg(input t_cfg_idx idx, input logic [DIM_W-1:0] d);
        t_stim_row r;
        r = '{ROW_CFG, idx, d, '0, 1'b0, '0};
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(99);
        if (r < 60) return DIM_W'($urandom_range(1, 4));
        if (r < 78) return DIM_W'($urandom_range(5, 8));
        if (r < 88) return '0;
        return DIM_W'($urandom_range(9, 15));
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_element();
        int r;
        r = $urandom_range(99);
        if (r < 10) begin
            case ($urandom_range(4))
                0: return ELEM_MIN;
                1: return ELEM_MAX;
                2: return '0;
                3: return -1;
                default: return 1;
            endcase
        end
        // narrow range gives plenty of equal keys
        if (r < 40) return $signed(DATA_W'($urandom_range(16))) - 8;
        return $signed(DATA_W'($urandom));
    endfunction

    task automatic set_idling(input int mode);
        case (mode)
            1: begin
                gap_pct   = 58;
                stall_pct = 0;
            end
            2: begin
                gap_pct   = 0;
                stall_pct = 58;
            end
            3: begin
                gap_pct   = 16;
                stall_pct = 16;
            end
            default: begin
                gap_pct   = 0;
                stall_pct = 0;
            end
        endcase
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [DIM_W-1:0] d);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= d;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_ROW_COUNT) model_rows = d;
        else model_cols = d;
    endtask

    task automatic send_element(input logic signed [DATA_W-1:0] v, input bit typed,
                                input t_sorted_item typed_item);
        int gap = 0;
        while (gap < 8 && $urandom_range(99) < gap_pct) gap++;
        @(negedge i_clk);
        repeat (gap) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid   <= 1'b1;
        in_element <= v;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        load_and_sort(v);
        if (typed) begin
            expected_sorted.push_back(typed_item);
            fresh_items.delete();
        end else begin
            while (fresh_items.size() != 0) expected_sorted.push_back(fresh_items.pop_front());
        end
    endtask

    // sender goes quiet until every predicted item is out, then settles
    task automatic wait_results(input int settle);
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (expected_sorted.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_output
        t_sorted_item got;
        t_sorted_item want;
        if (rst_n && out_valid && !out_stall) begin
            got = '{out_value, out_row, out_col, out_last};
            if (expected_sorted.size() == 0) begin
                note_failure($sformatf("unexpected item value=%0d row=%0d col=%0d last=%0b",
                                       got.value, got.row, got.col, got.last));
            end else begin
                want = expected_sorted.pop_front();
                if (got.value !== want.value || got.row !== want.row ||
                    got.col !== want.col || got.last !== want.last) begin
                    note_failure($sformatf(
                        "mismatch exp value=%0d row=%0d col=%0d last=%0b, got value=%0d row=%0d col=%0d last=%0b",
                        want.value, want.row, want.col, want.last,
                        got.value, got.row, got.col, got.last));
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("matrix_full_sorter test failed");
        $finish;
    end

    initial begin
        int               phase;
        int               sent;
        int unsigned      total;
        int               nmat;
        bit               pressure;
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;

        // partial load under reset sizes, then shrink mid-load
        directed_rows.push_back(stim_elem(100));
        directed_rows.push_back(stim_elem(-5));
        directed_rows.push_back(stim_elem(ELEM_MAX));
        directed_rows.push_back(stim_cfg(CFG_ROW_COUNT, 4'd1));
        directed_rows.push_back(stim_cfg(CFG_COL_COUNT, 4'd2));
        directed_rows.push_back(stim_elem(7));
        // zero sizes act as one
        directed_rows.push_back(stim_cfg(CFG_ROW_COUNT, 4'd0));
        directed_rows.push_back(stim_cfg(CFG_COL_COUNT, 4'd0));
        directed_rows.push_back(stim_single(ELEM_MIN));
        directed_rows.push_back(stim_single(ELEM_MAX));
        directed_rows.push_back(stim_single(-1));
        directed_rows.push_back(stim_single(0));
        // oversized row count clamps to eight
        directed_rows.push_back(stim_cfg(CFG_ROW_COUNT, 4'd15));
        directed_rows.push_back(stim_cfg(CFG_COL_COUNT, 4'd1));
        directed_rows.push_back(stim_elem(ELEM_MAX));
        directed_rows.push_back(stim_elem(ELEM_MIN));
        directed_rows.push_back(stim_elem(0));
        directed_rows.push_back(stim_elem(-1));
        directed_rows.push_back(stim_elem(1));
        directed_rows.push_back(stim_elem(ELEM_MAX));
        directed_rows.push_back(stim_elem(ELEM_MIN));
        directed_rows.push_back(stim_elem(32'sh5555_5555));
        directed_rows.push_back(stim_cfg(CFG_ROW_COUNT, 4'd2));
        directed_rows.push_back(stim_cfg(CFG_COL_COUNT, 4'd3));
        for (int v = 3; v >= -2; v--) directed_rows.push_back(stim_elem(v));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        foreach (directed_rows[n]) begin
            if (directed_rows[n].kind == ROW_CFG) begin
                if (n > 0 && directed_rows[n - 1].kind == ROW_ELEM) wait_results(DRAIN_CYCLES);
                cfg_write(directed_rows[n].idx, directed_rows[n].dim);
            end else begin
                send_element(directed_rows[n].element, directed_rows[n].typed,
                             directed_rows[n].typed_item);
            end
        end

        phase = 0;
        sent  = 0;
        while (sent < RANDOM_ITEMS) begin
            pressure = (phase == 2);
            if (pressure) begin
                rows = 4'd2;
                cols = 4'd2;
            end else if (phase % 7 == 5) begin
                rows = (phase % 2 == 0) ? 4'd8 : 4'd15;
                cols = 4'd8;
            end else begin
                rows = pick_dim();
                cols = pick_dim();
            end
            // any leftover partial load stays in place across the size change
            wait_results(DRAIN_CYCLES);
            cfg_write(CFG_ROW_COUNT, rows);
            cfg_write(CFG_COL_COUNT, cols);
            set_idling(pressure ? 0 : phase % 4);
            total = clamp_dim(rows) * clamp_dim(cols);
            if (pressure) nmat = 6;
            else if (total > 16) nmat = 1;
            else nmat = $urandom_range(1, 4);
            if (pressure) hold_reqs++;
            for (int m = 0; m < nmat; m++) begin
                for (int e = 0; e < total; e++) begin
                    send_element(pick_element(), 1'b0, '0);
                    sent++;
                end
                if ((phase == 1 && m == 0) || $urandom_range(9) == 0) wait_results(0);
            end
            // broken matrix: finished later under new sizes
            if ($urandom_range(99) < 15) begin
                repeat ($urandom_range(1, total)) begin
                    send_element(pick_element(), 1'b0, '0);
                    sent++;
                end
            end
            phase++;
        end

        wait_results(END_SETTLE);
        if (expected_sorted.size() != 0) failures++;
        if (failures == 0) begin
            $display("matrix_full_sorter test passed");
        end else begin
            $display("matrix_full_sorter test failed");
        end
        $finish;
    end

endmodule
